@@ rtl/core/brvm_pkg.sv @@
// ----------------------------------------------------------------------------
// brvm_pkg
// Shared widths, opcodes, status codes and the execute result record of the
// byte register machine.
// ----------------------------------------------------------------------------
package brvm_pkg;

   // default sizes of the register file and the data memory
   localparam int DEFAULT_REG_COUNT = 256;
   localparam int DEFAULT_MEM_BYTES = 8192;

   localparam int WORD_BITS     = 32;
   localparam int PC_BITS       = 16;
   localparam int ADDR_MAX_BITS = 16;
   localparam int OUT_ADDR_BITS = 13;
   localparam int LIMIT_BITS    = 14;
   localparam int LIMIT_RESET   = 8092;
   localparam int BYTE_VALUES   = 256;

   // register file read ports
   localparam int READ_PORTS = 3;
   localparam int PORT_DST   = 0;
   localparam int PORT_SRC_X = 1;
   localparam int PORT_SRC_Y = 2;

   typedef logic [2:0] status_type;
   localparam status_type ST_RUN    = 3'd0;
   localparam status_type ST_HALT   = 3'd1;
   localparam status_type ST_MEMERR = 3'd2;
   localparam status_type ST_STRIO  = 3'd3;
   localparam status_type ST_BADOP  = 3'd4;

   typedef logic [7:0] opcode_type;
   localparam opcode_type OP_HALT   = 8'h00;
   localparam opcode_type OP_LOAD   = 8'h10;
   localparam opcode_type OP_STORE  = 8'h20;
   localparam opcode_type OP_MOVE   = 8'h30;
   localparam opcode_type OP_PUT    = 8'h40;
   localparam opcode_type OP_ADD    = 8'h50;
   localparam opcode_type OP_SUB    = 8'h60;
   localparam opcode_type OP_GT     = 8'h70;
   localparam opcode_type OP_GE     = 8'h80;
   localparam opcode_type OP_EQ     = 8'h90;
   localparam opcode_type OP_BRANCH = 8'ha0;
   localparam opcode_type OP_JUMP   = 8'hb0;
   localparam opcode_type OP_STRIN  = 8'hc0;
   localparam opcode_type OP_STROUT = 8'hd0;

   // outcome of one instruction as seen by the pipeline control
   typedef struct packed {
      status_type               status;
      logic [PC_BITS-1:0]       next_pc;
      logic                     reg_wr;
      logic [WORD_BITS-1:0]     reg_val;
      logic                     mem_wr;
      logic [ADDR_MAX_BITS-1:0] mem_addr;
      logic [7:0]               mem_byte;
      logic                     is_load;
      logic                     stop;
   } exec_type;

endpackage

@@ rtl/core/byte_register_vm_execute.sv @@
// ----------------------------------------------------------------------------
// byte_register_vm_execute: an accepted word is registered into stage 1 and executed;
// its result is registered, a load first passing stage 2 for the data memory read;
// throughput 1 instruction per cycle while the result channel does not stall; a load
// stalls the input while the data memory read follows the register file read; reset is
// synchronous, then a clearing pass zeroes data memory and registers, input stalled
// ----------------------------------------------------------------------------
module byte_register_vm_execute import brvm_pkg::*; #(
   parameter int REG_COUNT = DEFAULT_REG_COUNT,
   parameter int MEM_BYTES = DEFAULT_MEM_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   // instruction channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [WORD_BITS-1:0]     req_instruction_word,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [PC_BITS-1:0]       rsp_next_pc,
   output logic                     rsp_reg_written,
   output logic [7:0]               rsp_reg_index,
   output logic [WORD_BITS-1:0]     rsp_reg_value,
   output logic                     rsp_mem_written,
   output logic [OUT_ADDR_BITS-1:0] rsp_mem_address,
   output logic [7:0]               rsp_mem_byte,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [LIMIT_BITS-1:0]    csr_wr_data
);

   localparam int RW   = $clog2(REG_COUNT);
   localparam int AW   = $clog2(MEM_BYTES);
   localparam int LIMW = $clog2(MEM_BYTES + 1);

   // register index lookup: operand byte modulo register count
   logic [RW-1:0] ridx_tab [BYTE_VALUES];
   for (genvar g = 0; g < BYTE_VALUES; g++) begin : g_ridx
      assign ridx_tab[g] = RW'(g % REG_COUNT);
   end

   // control and pipeline registers
   logic                     clearing_ff, clearing_in;
   logic [AW-1:0]            clr_cnt_ff, clr_cnt_in;
   logic                     running_ff, running_in;
   logic [PC_BITS-1:0]       pc_ff, pc_in;
   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;

   logic                     s1_valid_ff, s1_valid_in;
   opcode_type               s1_op_ff, s1_op_in;
   logic [7:0]               s1_b1_ff, s1_b1_in;
   logic [7:0]               s1_b2_ff, s1_b2_in;
   logic [7:0]               s1_b3_ff, s1_b3_in;
   logic [RW-1:0]            s1_d_ff, s1_d_in;
   logic [READ_PORTS-1:0]    s1_hit_ff, s1_hit_in;
   logic [WORD_BITS-1:0]     s1_fwd_ff, s1_fwd_in;

   logic                     s2_valid_ff, s2_valid_in;
   logic [RW-1:0]            s2_d_ff, s2_d_in;
   logic [PC_BITS-1:0]       s2_pc_ff, s2_pc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [PC_BITS-1:0]       rsp_next_pc_ff, rsp_next_pc_in;
   logic                     rsp_reg_written_ff, rsp_reg_written_in;
   logic [7:0]               rsp_reg_index_ff, rsp_reg_index_in;
   logic [WORD_BITS-1:0]     rsp_reg_value_ff, rsp_reg_value_in;
   logic                     rsp_mem_written_ff, rsp_mem_written_in;
   logic [OUT_ADDR_BITS-1:0] rsp_mem_address_ff, rsp_mem_address_in;
   logic [7:0]               rsp_mem_byte_ff, rsp_mem_byte_in;

   // datapath signals
   logic [READ_PORTS-1:0][RW-1:0]        rf_rd_addr;
   logic [READ_PORTS-1:0][WORD_BITS-1:0] rf_rd_data;
   logic                                 rf_wr_en;
   logic [RW-1:0]                        rf_wr_addr;
   logic [WORD_BITS-1:0]                 rf_wr_data;
   logic                                 exw_en;
   logic [RW-1:0]                        exw_addr;
   logic [WORD_BITS-1:0]                 exw_data;
   logic                                 dm_wr_en;
   logic [AW-1:0]                        dm_wr_addr;
   logic [7:0]                           dm_wr_data;
   logic                                 dm_rd_en;
   logic [7:0]                           dm_rd_data;
   logic [WORD_BITS-1:0]                 a_val, x_val, y_val;
   logic [LIMW-1:0]                      lim_eff;
   exec_type                             ex;
   logic                                 clr_last;
   logic                                 req_fire;
   logic                                 out_free;
   logic                                 s1_drop, s1_load_ok, s1_adv, s1_wr;
   logic                                 s2_adv;
   logic                                 rsp_load;

   // handshake and stage advance
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_drop    = !running_ff;
   assign s1_load_ok = s1_valid_ff && running_ff && ex.is_load;
   assign s1_adv     = s1_valid_ff && (s1_drop || s1_load_ok || out_free);
   assign s1_wr      = s1_adv && !s1_drop && ex.reg_wr && !ex.is_load;
   assign s2_adv     = s2_valid_ff && out_free;
   assign rsp_load   = s2_adv || (s1_adv && !s1_drop && !s1_load_ok);
   assign req_stall  = clearing_ff || (s1_valid_ff && (!s1_adv || s1_load_ok)) ||
                       (s2_valid_ff && !out_free);
   assign req_fire   = req_valid && !req_stall;
   assign clr_last   = clr_cnt_ff == AW'(MEM_BYTES - 1);

   // effective memory limit
   assign lim_eff = (32'(limit_ff) > MEM_BYTES) ? LIMW'(MEM_BYTES) : LIMW'(limit_ff);

   // register file reads issued with the incoming transaction
   assign rf_rd_addr[PORT_DST]   = ridx_tab[req_instruction_word[15:8]];
   assign rf_rd_addr[PORT_SRC_X] = ridx_tab[req_instruction_word[23:16]];
   assign rf_rd_addr[PORT_SRC_Y] = ridx_tab[req_instruction_word[31:24]];

   // write back from execute or from a finished load
   always_comb begin
      if (s2_adv) begin
         exw_en   = 1'b1;
         exw_addr = s2_d_ff;
         exw_data = WORD_BITS'(dm_rd_data);
      end else begin
         exw_en   = s1_wr;
         exw_addr = s1_d_ff;
         exw_data = ex.reg_val;
      end
   end

   // clearing pass owns the write ports after reset
   always_comb begin
      if (clearing_ff) begin
         rf_wr_en   = 32'(clr_cnt_ff) < REG_COUNT;
         rf_wr_addr = clr_cnt_ff[RW-1:0];
         rf_wr_data = '0;
         dm_wr_en   = 1'b1;
         dm_wr_addr = clr_cnt_ff;
         dm_wr_data = '0;
      end else begin
         rf_wr_en   = exw_en;
         rf_wr_addr = exw_addr;
         rf_wr_data = exw_data;
         dm_wr_en   = s1_adv && !s1_drop && ex.mem_wr;
         dm_wr_addr = ex.mem_addr[AW-1:0];
         dm_wr_data = ex.mem_byte;
      end
   end

   assign dm_rd_en = s1_adv && s1_load_ok;

   // operands with forwarding of the write that lands on the read edge
   assign a_val = s1_hit_ff[PORT_DST]   ? s1_fwd_ff : rf_rd_data[PORT_DST];
   assign x_val = s1_hit_ff[PORT_SRC_X] ? s1_fwd_ff : rf_rd_data[PORT_SRC_X];
   assign y_val = s1_hit_ff[PORT_SRC_Y] ? s1_fwd_ff : rf_rd_data[PORT_SRC_Y];

   brvm_regfile #(
      .REG_COUNT (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (rf_wr_en),
      .wr_addr (rf_wr_addr),
      .wr_data (rf_wr_data),
      .rd_en   (req_fire),
      .rd_addr (rf_rd_addr),
      .rd_data (rf_rd_data)
   );

   brvm_ram #(
      .WIDTH (8),
      .DEPTH (MEM_BYTES)
   ) u_dmem (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (dm_wr_addr),
      .wr_data (dm_wr_data),
      .rd_en   (dm_rd_en),
      .rd_addr (ex.mem_addr[AW-1:0]),
      .rd_data (dm_rd_data)
   );

   brvm_alu u_alu (
      .op    (s1_op_ff),
      .b1    (s1_b1_ff),
      .b2    (s1_b2_ff),
      .b3    (s1_b3_ff),
      .a_val (a_val),
      .x_val (x_val),
      .y_val (y_val),
      .pc    (pc_ff),
      .limit (WORD_BITS'(lim_eff)),
      .ex    (ex)
   );

   // next state of control, machine state and clearing pass
   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      running_in  = running_ff;
      pc_in       = pc_ff;
      limit_in    = limit_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_last) begin
            clearing_in = 1'b0;
         end
      end
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
      if (s1_adv && !s1_drop) begin
         pc_in      = ex.next_pc;
         running_in = !ex.stop;
      end
   end

   // stage 1: instruction with its register reads in flight
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_b1_in    = s1_b1_ff;
      s1_b2_in    = s1_b2_ff;
      s1_b3_in    = s1_b3_ff;
      s1_d_in     = s1_d_ff;
      s1_hit_in   = s1_hit_ff;
      s1_fwd_in   = s1_fwd_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_instruction_word[7:0];
         s1_b1_in    = req_instruction_word[15:8];
         s1_b2_in    = req_instruction_word[23:16];
         s1_b3_in    = req_instruction_word[31:24];
         s1_d_in     = rf_rd_addr[PORT_DST];
         s1_fwd_in   = exw_data;
         for (int p = 0; p < READ_PORTS; p++) begin
            s1_hit_in[p] = exw_en && (exw_addr == rf_rd_addr[p]);
         end
      end
   end

   // stage 2: load waiting on data memory
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_d_in     = s2_d_ff;
      s2_pc_in    = s2_pc_ff;
      if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      if (dm_rd_en) begin
         s2_valid_in = 1'b1;
         s2_d_in     = s1_d_ff;
         s2_pc_in    = ex.next_pc;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_next_pc_in     = rsp_next_pc_ff;
      rsp_reg_written_in = rsp_reg_written_ff;
      rsp_reg_index_in   = rsp_reg_index_ff;
      rsp_reg_value_in   = rsp_reg_value_ff;
      rsp_mem_written_in = rsp_mem_written_ff;
      rsp_mem_address_in = rsp_mem_address_ff;
      rsp_mem_byte_in    = rsp_mem_byte_ff;
      if (s2_adv) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ST_RUN;
         rsp_next_pc_in     = s2_pc_ff;
         rsp_reg_written_in = 1'b1;
         rsp_reg_index_in   = 8'(s2_d_ff);
         rsp_reg_value_in   = WORD_BITS'(dm_rd_data);
         rsp_mem_written_in = 1'b0;
         rsp_mem_address_in = '0;
         rsp_mem_byte_in    = '0;
      end else if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ex.status;
         rsp_next_pc_in     = ex.next_pc;
         rsp_reg_written_in = ex.reg_wr;
         rsp_reg_index_in   = ex.reg_wr ? 8'(s1_d_ff) : '0;
         rsp_reg_value_in   = ex.reg_val;
         rsp_mem_written_in = ex.mem_wr;
         rsp_mem_address_in = ex.mem_wr ? ex.mem_addr[OUT_ADDR_BITS-1:0] : '0;
         rsp_mem_byte_in    = ex.mem_byte;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         running_ff   <= 1'b1;
         pc_ff        <= '0;
         limit_ff     <= LIMIT_BITS'(LIMIT_RESET);
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         running_ff   <= running_in;
         pc_ff        <= pc_in;
         limit_ff     <= limit_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_op_ff           <= s1_op_in;
      s1_b1_ff           <= s1_b1_in;
      s1_b2_ff           <= s1_b2_in;
      s1_b3_ff           <= s1_b3_in;
      s1_d_ff            <= s1_d_in;
      s1_hit_ff          <= s1_hit_in;
      s1_fwd_ff          <= s1_fwd_in;
      s2_d_ff            <= s2_d_in;
      s2_pc_ff           <= s2_pc_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_next_pc_ff     <= rsp_next_pc_in;
      rsp_reg_written_ff <= rsp_reg_written_in;
      rsp_reg_index_ff   <= rsp_reg_index_in;
      rsp_reg_value_ff   <= rsp_reg_value_in;
      rsp_mem_written_ff <= rsp_mem_written_in;
      rsp_mem_address_ff <= rsp_mem_address_in;
      rsp_mem_byte_ff    <= rsp_mem_byte_in;
   end

   // result ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_next_pc     = rsp_next_pc_ff;
   assign rsp_reg_written = rsp_reg_written_ff;
   assign rsp_reg_index   = rsp_reg_index_ff;
   assign rsp_reg_value   = rsp_reg_value_ff;
   assign rsp_mem_written = rsp_mem_written_ff;
   assign rsp_mem_address = rsp_mem_address_ff;
   assign rsp_mem_byte    = rsp_mem_byte_ff;

`ifndef ASSERT_OFF
   // a load in its memory cycle never shares the pipe with another instruction
   a_one_stage: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("stage 1 and load stage both occupied");

   // a stopped machine delivers no further result
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> !rsp_load)
      else $error("result produced after machine stopped");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten while stalled");
`endif

endmodule

@@ rtl/core/brvm_ram.sv @@
// ----------------------------------------------------------------------------
// brvm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/brvm_regfile.sv @@
// ----------------------------------------------------------------------------
// brvm_regfile
// Register file with one write port and three read ports, built from
// replicated RAM copies that all take the same write.
// ----------------------------------------------------------------------------
module brvm_regfile import brvm_pkg::*; #(
   parameter int REG_COUNT = DEFAULT_REG_COUNT
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [$clog2(REG_COUNT)-1:0]                   wr_addr,
   input  logic [WORD_BITS-1:0]                           wr_data,
   input  logic                                           rd_en,
   input  logic [READ_PORTS-1:0][$clog2(REG_COUNT)-1:0]   rd_addr,
   output logic [READ_PORTS-1:0][WORD_BITS-1:0]           rd_data
);

   // one copy per read port
   for (genvar p = 0; p < READ_PORTS; p++) begin : g_copy
      brvm_ram #(
         .WIDTH (WORD_BITS),
         .DEPTH (REG_COUNT)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_addr[p]),
         .rd_data (rd_data[p])
      );
   end

endmodule

@@ rtl/core/brvm_alu.sv @@
// ----------------------------------------------------------------------------
// brvm_alu
// Instruction decode and execute: arithmetic, compares, branch targets,
// address checks and the status of one instruction.
// ----------------------------------------------------------------------------
module brvm_alu import brvm_pkg::*; (
   input  opcode_type           op,
   input  logic [7:0]           b1,
   input  logic [7:0]           b2,
   input  logic [7:0]           b3,
   input  logic [WORD_BITS-1:0] a_val,
   input  logic [WORD_BITS-1:0] x_val,
   input  logic [WORD_BITS-1:0] y_val,
   input  logic [PC_BITS-1:0]   pc,
   input  logic [WORD_BITS-1:0] limit,
   output exec_type             ex
);

   logic               a_ok;
   logic               x_ok;
   logic [PC_BITS-1:0] pc_inc;

   // address range checks against the effective limit
   assign a_ok   = a_val < limit;
   assign x_ok   = x_val < limit;
   assign pc_inc = pc + PC_BITS'(1);

   // decode and execute
   always_comb begin
      ex         = '0;
      ex.status  = ST_RUN;
      ex.next_pc = pc_inc;
      unique case (op) inside
         OP_HALT: begin
            ex.status  = ST_HALT;
            ex.next_pc = pc;
         end
         OP_LOAD: begin
            if (x_ok) begin
               ex.reg_wr   = 1'b1;
               ex.is_load  = 1'b1;
               ex.mem_addr = x_val[ADDR_MAX_BITS-1:0];
            end else begin
               ex.status  = ST_MEMERR;
               ex.next_pc = pc;
            end
         end
         OP_STORE: begin
            if (a_ok) begin
               ex.mem_wr   = 1'b1;
               ex.mem_addr = a_val[ADDR_MAX_BITS-1:0];
               ex.mem_byte = x_val[7:0];
            end else begin
               ex.status  = ST_MEMERR;
               ex.next_pc = pc;
            end
         end
         OP_MOVE: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = x_val;
         end
         OP_PUT: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = WORD_BITS'(b2);
         end
         OP_ADD: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = x_val + y_val;
         end
         OP_SUB: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = x_val - y_val;
         end
         OP_GT: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = WORD_BITS'(x_val > y_val);
         end
         OP_GE: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = WORD_BITS'(x_val >= y_val);
         end
         OP_EQ: begin
            ex.reg_wr  = 1'b1;
            ex.reg_val = WORD_BITS'(x_val == y_val);
         end
         OP_BRANCH: begin
            ex.next_pc = (a_val != '0) ? PC_BITS'(b2) : PC_BITS'(b3);
         end
         OP_JUMP: begin
            ex.next_pc = PC_BITS'(b1);
         end
         OP_STRIN, OP_STROUT: begin
            if (a_ok) begin
               ex.status = ST_STRIO;
            end else begin
               ex.status  = ST_MEMERR;
               ex.next_pc = pc;
            end
         end
         default: begin
            ex.status  = ST_BADOP;
            ex.next_pc = pc;
         end
      endcase
      ex.stop = (ex.status == ST_HALT) || (ex.status == ST_MEMERR) ||
                (ex.status == ST_BADOP);
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for byte_register_vm_execute
// Drives instruction words through the valid/stall channel under random
// idling, back-pressure and several memory limit settings. A scoreboard
// executes each accepted word on its own copy of the registers, memory and
// pc, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
   import brvm_pkg::*;

   localparam int IDLE_LIMIT    = 40000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PERCENT  = 36;
   localparam int PHASE_ITEMS   = 90;

   // opcodes that keep the machine running
   localparam opcode_type RUNNING_OPS [13] = '{
      OP_LOAD, OP_STORE, OP_MOVE, OP_PUT, OP_ADD, OP_SUB, OP_GT,
      OP_GE, OP_EQ, OP_BRANCH, OP_JUMP, OP_STRIN, OP_STROUT
   };

   typedef struct packed {
      status_type               status;
      logic [PC_BITS-1:0]       next_pc;
      logic                     reg_written;
      logic [7:0]               reg_index;
      logic [WORD_BITS-1:0]     reg_value;
      logic                     mem_written;
      logic [OUT_ADDR_BITS-1:0] mem_address;
      logic [7:0]               mem_byte;
   } vm_outcome_type;

   // machine state copy and the queue of outcomes still to arrive
   class vm_outcome_board;
      logic [WORD_BITS-1:0]  regs [DEFAULT_REG_COUNT];
      logic [7:0]            mem [DEFAULT_MEM_BYTES];
      logic [PC_BITS-1:0]    pc;
      bit                    running;
      logic [LIMIT_BITS-1:0] limit;
      vm_outcome_type        outcome_q [$];
      int                    mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         pc = '0;
         running = 1'b1;
         limit = LIMIT_BITS'(LIMIT_RESET);
         mismatches = 0;
      endfunction

      function void set_limit(logic [LIMIT_BITS-1:0] value);
         limit = value;
      endfunction

      // limit clamped to the memory size
      function int unsigned usable_bytes();
         return (limit > DEFAULT_MEM_BYTES) ? DEFAULT_MEM_BYTES : limit;
      endfunction

      function bit addr_fits(logic [WORD_BITS-1:0] addr);
         return addr < usable_bytes();
      endfunction

      // execute one accepted word and queue the outcome it produces
      function void execute_word(logic [WORD_BITS-1:0] word);
         opcode_type           op;
         logic [7:0]           b1, b2, b3;
         logic [WORD_BITS-1:0] x, y, rv;
         status_type           st;
         logic [PC_BITS-1:0]   npc;
         bit                   rw, mw;
         logic [12:0]          ma;
         logic [7:0]           mb;
         vm_outcome_type       o;
         if (!running) return;
         op = word[7:0];
         b1 = word[15:8];
         b2 = word[23:16];
         b3 = word[31:24];
         x = regs[b2];
         y = regs[b3];
         st = ST_RUN;
         npc = pc + 1'b1;
         rw = 1'b0;
         mw = 1'b0;
         rv = '0;
         ma = '0;
         mb = '0;
         case (op)
            OP_HALT: begin
               st = ST_HALT;
               npc = pc;
            end
            OP_LOAD: begin
               if (addr_fits(x)) begin
                  rw = 1'b1;
                  rv = {24'd0, mem[x[12:0]]};
               end else begin
                  st = ST_MEMERR;
                  npc = pc;
               end
            end
            OP_STORE: begin
               if (addr_fits(regs[b1])) begin
                  mw = 1'b1;
                  ma = regs[b1][12:0];
                  mb = x[7:0];
               end else begin
                  st = ST_MEMERR;
                  npc = pc;
               end
            end
            OP_MOVE: begin
               rw = 1'b1;
               rv = x;
            end
            OP_PUT: begin
               rw = 1'b1;
               rv = {24'd0, b2};
            end
            OP_ADD: begin
               rw = 1'b1;
               rv = x + y;
            end
            OP_SUB: begin
               rw = 1'b1;
               rv = x - y;
            end
            OP_GT: begin
               rw = 1'b1;
               rv = (x > y) ? 32'd1 : 32'd0;
            end
            OP_GE: begin
               rw = 1'b1;
               rv = (x >= y) ? 32'd1 : 32'd0;
            end
            OP_EQ: begin
               rw = 1'b1;
               rv = (x == y) ? 32'd1 : 32'd0;
            end
            OP_BRANCH: begin
               npc = (regs[b1] != 0) ? {8'd0, b2} : {8'd0, b3};
            end
            OP_JUMP: begin
               npc = {8'd0, b1};
            end
            OP_STRIN, OP_STROUT: begin
               if (addr_fits(regs[b1])) begin
                  st = ST_STRIO;
               end else begin
                  st = ST_MEMERR;
                  npc = pc;
               end
            end
            default: begin
               st = ST_BADOP;
               npc = pc;
            end
         endcase
         if (rw) regs[b1] = rv;
         if (mw) mem[ma] = mb;
         pc = npc;
         if (st == ST_HALT || st == ST_MEMERR || st == ST_BADOP) running = 1'b0;
         o.status = st;
         o.next_pc = npc;
         o.reg_written = rw;
         o.reg_index = rw ? b1 : 8'd0;
         o.reg_value = rv;
         o.mem_written = mw;
         o.mem_address = ma;
         o.mem_byte = mb;
         outcome_q.push_back(o);
      endfunction

      task report_mismatch(string what);
         $display("ERROR at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      // compare one result transaction with the oldest pending outcome
      task check_result(vm_outcome_type got);
         vm_outcome_type want;
         if (outcome_q.size() == 0) begin
            report_mismatch("result transaction with no instruction pending");
         end else begin
            want = outcome_q.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("next_pc", 32'(got.next_pc), 32'(want.next_pc));
            compare_field("reg_written", 32'(got.reg_written), 32'(want.reg_written));
            compare_field("reg_index", 32'(got.reg_index), 32'(want.reg_index));
            compare_field("reg_value", got.reg_value, want.reg_value);
            compare_field("mem_written", 32'(got.mem_written), 32'(want.mem_written));
            compare_field("mem_address", 32'(got.mem_address), 32'(want.mem_address));
            compare_field("mem_byte", 32'(got.mem_byte), 32'(want.mem_byte));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [WORD_BITS-1:0]     req_instruction_word;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [2:0]               rsp_status;
   logic [PC_BITS-1:0]       rsp_next_pc;
   logic                     rsp_reg_written;
   logic [7:0]               rsp_reg_index;
   logic [WORD_BITS-1:0]     rsp_reg_value;
   logic                     rsp_mem_written;
   logic [OUT_ADDR_BITS-1:0] rsp_mem_address;
   logic [7:0]               rsp_mem_byte;
   logic                     csr_wr_en;
   logic [LIMIT_BITS-1:0]    csr_wr_data;

   vm_outcome_board      board;
   logic [WORD_BITS-1:0] plan_q [$];
   int                   sent_count = 0;
   int                   results_seen = 0;
   int                   hold_left = 0;
   int                   idle_cycles = 0;

   byte_register_vm_execute DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_instruction_word (req_instruction_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_reg_written      (rsp_reg_written),
      .rsp_reg_index        (rsp_reg_index),
      .rsp_reg_value        (rsp_reg_value),
      .rsp_mem_written      (rsp_mem_written),
      .rsp_mem_address      (rsp_mem_address),
      .rsp_mem_byte         (rsp_mem_byte),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] encode(opcode_type op, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3);
      return {b3, b2, b1, op};
   endfunction

   // load a 16-bit address into register a, using a neighbor as scratch
   function automatic void plan_address(logic [7:0] a, logic [15:0] target);
      logic [7:0] c;
      c = a ^ 8'h01;
      plan_q.push_back(encode(OP_PUT, a, target[15:8], 8'd0));
      if (target[15:8] != 0) repeat (8) plan_q.push_back(encode(OP_ADD, a, a, a));
      plan_q.push_back(encode(OP_PUT, c, target[7:0], 8'd0));
      plan_q.push_back(encode(OP_ADD, a, a, c));
   endfunction

   // one load, store or string io word addressed by register a
   function automatic void plan_memory_op(logic [7:0] a);
      case ($urandom_range(0, 2))
         0: plan_q.push_back(encode(OP_LOAD, 8'($urandom_range(0, 255)), a,
                                    8'($urandom_range(0, 255))));
         1: plan_q.push_back(encode(OP_STORE, a, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255))));
         default: plan_q.push_back(encode($urandom_range(0, 1) ? OP_STRIN : OP_STROUT,
                                          a, 8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 255))));
      endcase
   endfunction

   // a random running word; memory ops with an out-of-range address get an in-range one first
   function automatic void plan_random_op();
      opcode_type  op;
      logic [7:0]  b1, b2, b3, ar;
      int unsigned top;
      op = RUNNING_OPS[$urandom_range(0, 12)];
      b1 = 8'($urandom_range(0, 255));
      b2 = 8'($urandom_range(0, 255));
      b3 = 8'($urandom_range(0, 255));
      ar = (op == OP_LOAD) ? b2 : b1;
      if ((op == OP_LOAD || op == OP_STORE || op == OP_STRIN || op == OP_STROUT) &&
          !board.addr_fits(board.regs[ar])) begin
         top = board.usable_bytes() - 1;
         if (top > 255) top = 255;
         plan_q.push_back(encode(OP_PUT, ar, 8'($urandom_range(0, top)), 8'd0));
      end
      plan_q.push_back(encode(op, b1, b2, b3));
   endfunction

   // offer one instruction transaction and hold it until accepted
   task send_word(logic [WORD_BITS-1:0] word);
      req_instruction_word <= word;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      board.execute_word(word);
      sent_count++;
      if (!(sent_count >= 200 && sent_count < 280)) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task send_plan();
      while (plan_q.size() != 0) send_word(plan_q.pop_front());
   endtask

   // wait for every pending outcome, then let the pipeline settle
   task drain();
      req_valid <= 1'b0;
      while (board.outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_mem_limit(logic [LIMIT_BITS-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_limit(value);
   endtask

   // random words: mostly single ops, some address-building sequences
   task run_random(int count);
      int          sent_here;
      logic [7:0]  a;
      sent_here = 0;
      while (sent_here < count || plan_q.size() != 0) begin
         if (plan_q.size() == 0) begin
            if ($urandom_range(0, 99) < 15) begin
               a = 8'($urandom_range(0, 255));
               plan_address(a, 16'($urandom_range(0, board.usable_bytes() - 1)));
               plan_memory_op(a);
            end else begin
               plan_random_op();
            end
         end
         send_word(plan_q.pop_front());
         sent_here++;
      end
   endtask

   // stimulus
   initial begin
      logic [WORD_BITS-1:0] opening_words [24];
      int unsigned          phase_limit [6];
      opcode_type           bad_op;
      logic [7:0]           a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_instruction_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      board = new();
      opening_words = '{
         encode(OP_PUT, 8'd1, 8'd255, 8'd0),
         encode(OP_PUT, 8'd0, 8'd0, 8'd0),
         encode(OP_SUB, 8'd2, 8'd0, 8'd1),
         encode(OP_ADD, 8'd3, 8'd2, 8'd2),
         encode(OP_MOVE, 8'd255, 8'd2, 8'd0),
         encode(OP_GT, 8'd4, 8'd2, 8'd1),
         encode(OP_GT, 8'd5, 8'd1, 8'd1),
         encode(OP_GE, 8'd6, 8'd1, 8'd1),
         encode(OP_GE, 8'd7, 8'd1, 8'd2),
         encode(OP_EQ, 8'd8, 8'd1, 8'd1),
         encode(OP_EQ, 8'd9, 8'd0, 8'd1),
         encode(OP_STORE, 8'd0, 8'd1, 8'd0),
         encode(OP_STORE, 8'd1, 8'd2, 8'd0),
         encode(OP_LOAD, 8'd10, 8'd0, 8'd0),
         encode(OP_LOAD, 8'd11, 8'd1, 8'd0),
         encode(OP_PUT, 8'd12, 8'd100, 8'd0),
         encode(OP_LOAD, 8'd13, 8'd12, 8'd0),
         encode(OP_BRANCH, 8'd1, 8'h12, 8'h34),
         encode(OP_BRANCH, 8'd0, 8'h56, 8'hff),
         encode(OP_JUMP, 8'd255, 8'd0, 8'd0),
         encode(OP_JUMP, 8'd0, 8'd255, 8'd255),
         encode(OP_STRIN, 8'd1, 8'd0, 8'd0),
         encode(OP_STROUT, 8'd0, 8'd0, 8'd0),
         encode(OP_MOVE, 8'd0, 8'd255, 8'd255)
      };
      phase_limit = '{1, 8192, 16383, $urandom_range(2, 8191), 255,
                      $urandom_range(1, 16383)};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words under the reset limit
      foreach (opening_words[i]) send_word(opening_words[i]);

      // random phases, one memory limit each
      foreach (phase_limit[i]) begin
         drain();
         write_mem_limit(LIMIT_BITS'(phase_limit[i]));
         run_random(PHASE_ITEMS);
      end

      // stop the machine once, by halt, bad opcode or address fault
      case ($urandom_range(0, 3))
         0: plan_q.push_back(encode(OP_HALT, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255))));
         1: begin
            do bad_op = 8'($urandom_range(0, 255));
            while (bad_op[3:0] == 4'd0 && bad_op <= OP_STROUT);
            plan_q.push_back(encode(bad_op, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255))));
         end
         2: begin
            // a zero limit faults every access
            drain();
            write_mem_limit('0);
            plan_memory_op(8'($urandom_range(0, 255)));
         end
         default: begin
            a = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
               plan_address(a, 16'(board.usable_bytes()));
            end else begin
               plan_q.push_back(encode(OP_PUT, a, 8'd0, 8'd0));
               plan_q.push_back(encode(OP_PUT, a ^ 8'h01, 8'd1, 8'd0));
               plan_q.push_back(encode(OP_SUB, a, a, a ^ 8'h01));
            end
            plan_memory_op(a);
         end
      endcase
      send_plan();

      // a stopped machine ignores anything that follows
      repeat (8) send_word($urandom());

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.outcome_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result receiver with random stalls and long hold-offs
   initial begin
      vm_outcome_type got;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.status = rsp_status;
            got.next_pc = rsp_next_pc;
            got.reg_written = rsp_reg_written;
            got.reg_index = rsp_reg_index;
            got.reg_value = rsp_reg_value;
            got.mem_written = rsp_mem_written;
            got.mem_address = rsp_mem_address;
            got.mem_byte = rsp_mem_byte;
            board.check_result(got);
            results_seen++;
            if (results_seen == 120 || results_seen == 380) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (results_seen >= 200 && results_seen < 280) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule
